@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/core/cica_pkg.sv @@
// Shared types, codes and constants of the checked integer constant ALU.
`default_nettype none
package cica_pkg;
    localparam int WORD_WIDTH = 64;
    localparam int IN_BITS    = 144;
    localparam int OUT_BITS   = 72;

    localparam logic [4:0] OP_ADD = 5'd0;
    localparam logic [4:0] OP_SUB = 5'd1;
    localparam logic [4:0] OP_MUL = 5'd2;
    localparam logic [4:0] OP_DIV = 5'd3;
    localparam logic [4:0] OP_POW = 5'd4;
    localparam logic [4:0] OP_EQ  = 5'd5;
    localparam logic [4:0] OP_LT  = 5'd6;
    localparam logic [4:0] OP_GT  = 5'd7;
    localparam logic [4:0] OP_NEQ = 5'd8;
    localparam logic [4:0] OP_LTE = 5'd9;
    localparam logic [4:0] OP_GTE = 5'd10;
    localparam logic [4:0] OP_AND = 5'd11;
    localparam logic [4:0] OP_OR  = 5'd12;
    localparam logic [4:0] OP_SHL = 5'd13;
    localparam logic [4:0] OP_SHR = 5'd14;
    localparam logic [4:0] OP_POS = 5'd15;
    localparam logic [4:0] OP_NEG = 5'd16;
    localparam logic [4:0] OP_NOT = 5'd17;

    localparam logic [1:0] KIND_INT  = 2'd0;
    localparam logic [1:0] KIND_BOOL = 2'd1;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_NF  = 2'd1;
    localparam logic [1:0] ST_OVF = 2'd2;

    // Which unit finishes the item after the first evaluation cycle.
    localparam logic [1:0] CL_FAST = 2'd0;
    localparam logic [1:0] CL_MUL  = 2'd1;
    localparam logic [1:0] CL_DIV  = 2'd2;
    localparam logic [1:0] CL_POW  = 2'd3;

    localparam logic [1:0] SRC_AB  = 2'd0;
    localparam logic [1:0] SRC_ACC = 2'd1;
    localparam logic [1:0] SRC_SQR = 2'd2;

    localparam logic [WORD_WIDTH-1:0] MAG_POS_MAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
    localparam logic [WORD_WIDTH-1:0] MAG_NEG_MAX = {1'b1, {(WORD_WIDTH-1){1'b0}}};

    typedef struct packed {
        logic       load;
        logic       eval_wb;
        logic       mul_start;
        logic [1:0] mul_src;
        logic       mul_step;
        logic       mul_fin;
        logic       div_start;
        logic       div_step;
        logic       div_fin;
        logic       pow_init;
        logic       pow_acc_wb;
        logic       pow_sq_wb;
        logic       pow_fin;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic [1:0] cls;
        logic       exp_zero;
        logic       exp_lsb;
        logic       out_busy;
    } t_stat;

    function automatic logic [WORD_WIDTH-1:0] mag(input logic [WORD_WIDTH-1:0] x);
        return x[WORD_WIDTH-1] ? (~x + 1'b1) : x;
    endfunction
endpackage
`default_nettype wire

@@ rtl/core/cica_ctrl.sv @@
// Controller state machine sequencing evaluation, multiply, divide and power.
`default_nettype none
module cica_ctrl
    import cica_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_EVAL = 4'd1;
    localparam logic [3:0] S_MUL  = 4'd2;
    localparam logic [3:0] S_MFIN = 4'd3;
    localparam logic [3:0] S_DIV  = 4'd4;
    localparam logic [3:0] S_DFIN = 4'd5;
    localparam logic [3:0] S_PTST = 4'd6;
    localparam logic [3:0] S_PMA  = 4'd7;
    localparam logic [3:0] S_PMAW = 4'd8;
    localparam logic [3:0] S_PMS  = 4'd9;
    localparam logic [3:0] S_PMSW = 4'd10;
    localparam logic [3:0] S_DONE = 4'd11;

    logic [3:0] r_state, n_state;
    logic [5:0] r_cnt, n_cnt;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt + 1'b1;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval_wb = 1'b1;
                n_cnt         = '0;
                unique case (i_stat.cls)
                    CL_MUL: begin
                        o_cmd.mul_start = 1'b1;
                        o_cmd.mul_src   = SRC_AB;
                        n_state         = S_MUL;
                    end
                    CL_DIV: begin
                        o_cmd.div_start = 1'b1;
                        n_state         = S_DIV;
                    end
                    CL_POW: begin
                        o_cmd.pow_init = 1'b1;
                        n_state        = S_PTST;
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                if (r_cnt == '1) n_state = S_MFIN;
            end
            S_MFIN: begin
                o_cmd.mul_fin = 1'b1;
                n_state       = S_DONE;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == '1) n_state = S_DFIN;
            end
            S_DFIN: begin
                o_cmd.div_fin = 1'b1;
                n_state       = S_DONE;
            end
            S_PTST: begin
                n_cnt = '0;
                priority if (i_stat.exp_zero) begin
                    o_cmd.pow_fin = 1'b1;
                    n_state       = S_DONE;
                end else if (i_stat.exp_lsb) begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_src   = SRC_ACC;
                    n_state         = S_PMA;
                end else begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_src   = SRC_SQR;
                    n_state         = S_PMS;
                end
            end
            S_PMA: begin
                o_cmd.mul_step = 1'b1;
                if (r_cnt == '1) n_state = S_PMAW;
            end
            S_PMAW: begin
                o_cmd.pow_acc_wb = 1'b1;
                n_state          = S_PTST;
            end
            S_PMS: begin
                o_cmd.mul_step = 1'b1;
                if (r_cnt == '1) n_state = S_PMSW;
            end
            S_PMSW: begin
                o_cmd.pow_sq_wb = 1'b1;
                n_state         = S_PTST;
            end
            S_DONE: begin
                if (!i_stat.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end
endmodule
`default_nettype wire

@@ rtl/core/cica_dp.sv @@
// Datapath: operand registers, fast evaluation, shared shift-add/subtract unit, output stage.
`default_nettype none
module cica_dp
    import cica_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cmd                  i_cmd,
    output t_stat                      o_stat,
    input  wire logic [IN_BITS-1:0]    i_data,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [OUT_BITS-1:0]        o_data
);
    localparam int W = WORD_WIDTH;

    logic [4:0]            r_op;
    logic [1:0]            r_cnt_ops, r_lk, r_rk;
    logic signed [W-1:0]   r_a, r_b;
    logic [W-1:0]          r_mx;
    logic [2*W-1:0]        r_prod;
    logic [W-1:0]          r_acc, r_base;
    logic [5:0]            r_exp;
    logic                  r_povf;
    logic [1:0]            r_st;
    logic [W-1:0]          r_val;
    logic                  r_isb;
    logic                  r_ovalid;
    logic [1:0]            r_ost;
    logic [W-1:0]          r_oval;
    logic                  r_oisb;

    logic [1:0]            e_st, e_cls;
    logic [W-1:0]          e_val;
    logic                  e_isb;
    logic                  ii, bo, ab, bb, cnt_ok, b_neg, b_big, prod_neg;
    logic signed [W:0]     sum, dif;
    logic [5:0]            sh;
    logic signed [W-1:0]   shl_v;
    logic [W-1:0]          mag_a, mag_b, lo, hi;
    logic                  lt, gt, eq;

    assign ii     = (r_lk == KIND_INT) && (r_rk == KIND_INT);
    assign bo     = (r_lk == KIND_BOOL) && (r_rk == KIND_BOOL);
    assign ab     = (r_a != '0);
    assign bb     = (r_b != '0);
    assign b_neg  = r_b[W-1];
    assign b_big  = (r_b >= W);
    assign sh     = r_b[5:0];
    assign sum    = {r_a[W-1], r_a} + {r_b[W-1], r_b};
    assign dif    = {r_a[W-1], r_a} - {r_b[W-1], r_b};
    assign shl_v  = r_a <<< sh;
    assign mag_a  = mag(r_a);
    assign mag_b  = mag(r_b);
    assign lt     = (r_a < r_b);
    assign gt     = (r_a > r_b);
    assign eq     = (r_a == r_b);
    assign lo     = r_prod[W-1:0];
    assign hi     = r_prod[2*W-1:W];
    assign prod_neg = r_a[W-1] ^ r_b[W-1];

    always_comb begin
        cnt_ok = (r_op <= OP_SHR) ? (r_cnt_ops == 2'd2) : (r_cnt_ops == 2'd1);
        e_st   = ST_NF;
        e_val  = '0;
        e_isb  = 1'b0;
        e_cls  = CL_FAST;
        if (cnt_ok) begin
            unique case (r_op)
                OP_ADD: if (ii) begin
                    e_st  = (sum[W] != sum[W-1]) ? ST_OVF : ST_OK;
                    e_val = sum[W-1:0];
                end
                OP_SUB: if (ii) begin
                    e_st  = (dif[W] != dif[W-1]) ? ST_OVF : ST_OK;
                    e_val = dif[W-1:0];
                end
                OP_MUL: if (ii) e_cls = CL_MUL;
                OP_DIV: if (ii && bb) begin
                    if (r_a == MAG_NEG_MAX && r_b == '1) e_st = ST_OVF;
                    else e_cls = CL_DIV;
                end
                OP_POW: if (ii && !b_neg) begin
                    priority if (r_a == '0) begin
                        e_st = ST_OK; e_val = {{(W-1){1'b0}}, !bb};
                    end else if (r_a == 1) begin
                        e_st = ST_OK; e_val = {{(W-1){1'b0}}, 1'b1};
                    end else if (r_a == '1) begin
                        e_st = ST_OK; e_val = r_b[0] ? '1 : {{(W-1){1'b0}}, 1'b1};
                    end else if (b_big) begin
                        e_st = ST_OVF;
                    end else begin
                        e_cls = CL_POW;
                    end
                end
                OP_EQ, OP_NEQ: if (ii || bo) begin
                    e_st  = ST_OK; e_isb = 1'b1;
                    e_val = {{(W-1){1'b0}}, (ii ? eq : (ab == bb)) ^ (r_op == OP_NEQ)};
                end
                OP_LT, OP_GTE: if (ii) begin
                    e_st  = ST_OK; e_isb = 1'b1;
                    e_val = {{(W-1){1'b0}}, lt ^ (r_op == OP_GTE)};
                end
                OP_GT, OP_LTE: if (ii) begin
                    e_st  = ST_OK; e_isb = 1'b1;
                    e_val = {{(W-1){1'b0}}, gt ^ (r_op == OP_LTE)};
                end
                OP_AND, OP_OR: if (bo) begin
                    e_st  = ST_OK; e_isb = 1'b1;
                    e_val = {{(W-1){1'b0}}, (r_op == OP_AND) ? (ab && bb) : (ab || bb)};
                end
                OP_SHL: if (ii && !b_neg && !b_big) begin
                    e_st  = ((shl_v >>> sh) != r_a) ? ST_OVF : ST_OK;
                    e_val = shl_v;
                end
                OP_SHR: if (ii && !b_neg && !b_big) begin
                    e_st = ST_OK; e_val = r_a >>> sh;
                end
                OP_POS: if (r_lk == KIND_INT) begin
                    e_st = ST_OK; e_val = r_a;
                end
                OP_NEG: if (r_lk == KIND_INT) begin
                    e_st  = (r_a == MAG_NEG_MAX) ? ST_OVF : ST_OK;
                    e_val = -r_a;
                end
                OP_NOT: if (r_lk == KIND_BOOL) begin
                    e_st = ST_OK; e_isb = 1'b1; e_val = {{(W-1){1'b0}}, !ab};
                end
                default: e_st = ST_NF;
            endcase
        end
    end

    // Shared iterative step: shift-add multiply or restoring divide.
    logic [W:0]   m_sum, d_rem, d_dif;
    logic         d_ge;
    assign m_sum = {1'b0, hi} + {1'b0, (r_prod[0] ? r_mx : '0)};
    assign d_rem = r_prod[2*W-1:W-1];
    assign d_ge  = (d_rem >= {1'b0, r_mx});
    assign d_dif = d_rem - {1'b0, r_mx};

    logic [W-1:0] mul_lim, pow_lim;
    logic         pow_neg;
    assign mul_lim = prod_neg ? MAG_NEG_MAX : MAG_POS_MAX;
    assign pow_neg = r_a[W-1] & r_b[0];
    assign pow_lim = pow_neg ? MAG_NEG_MAX : MAG_POS_MAX;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= i_data[4:0];
            r_cnt_ops <= i_data[6:5];
            r_lk      <= i_data[8:7];
            r_a       <= i_data[72:9];
            r_rk      <= i_data[74:73];
            r_b       <= i_data[138:75];
        end
        if (i_cmd.mul_start) begin
            unique case (i_cmd.mul_src)
                SRC_ACC: begin r_mx <= r_acc;  r_prod <= {{W{1'b0}}, r_base}; end
                SRC_SQR: begin r_mx <= r_base; r_prod <= {{W{1'b0}}, r_base}; end
                default: begin r_mx <= mag_a;  r_prod <= {{W{1'b0}}, mag_b}; end
            endcase
        end else if (i_cmd.div_start) begin
            r_mx   <= mag_b;
            r_prod <= {{W{1'b0}}, mag_a};
        end else if (i_cmd.mul_step) begin
            r_prod <= {m_sum, lo[W-1:1]};
        end else if (i_cmd.div_step) begin
            r_prod <= {(d_ge ? d_dif[W-1:0] : d_rem[W-1:0]), r_prod[W-2:0], d_ge};
        end
        if (i_cmd.pow_init) begin
            r_acc  <= {{(W-1){1'b0}}, 1'b1};
            r_base <= mag_a;
            r_exp  <= r_b[5:0];
            r_povf <= 1'b0;
        end else if (i_cmd.pow_acc_wb) begin
            r_acc    <= lo;
            r_povf   <= r_povf | (hi != '0);
            r_exp[0] <= 1'b0;
        end else if (i_cmd.pow_sq_wb) begin
            r_base <= lo;
            r_povf <= r_povf | (hi != '0);
            r_exp  <= {1'b0, r_exp[5:1]};
        end
        if (i_cmd.eval_wb) begin
            r_st  <= e_st;
            r_val <= (e_st == ST_OK) ? e_val : '0;
            r_isb <= (e_st == ST_OK) && e_isb;
        end else if (i_cmd.mul_fin) begin
            if (hi != '0 || lo > mul_lim) begin
                r_st <= ST_OVF; r_val <= '0;
            end else begin
                r_st <= ST_OK; r_val <= prod_neg ? -lo : lo;
            end
            r_isb <= 1'b0;
        end else if (i_cmd.div_fin) begin
            r_st  <= ST_OK;
            r_val <= prod_neg ? -lo : lo;
            r_isb <= 1'b0;
        end else if (i_cmd.pow_fin) begin
            if (r_povf || r_acc > pow_lim) begin
                r_st <= ST_OVF; r_val <= '0;
            end else begin
                r_st <= ST_OK; r_val <= pow_neg ? -r_acc : r_acc;
            end
            r_isb <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_ost  <= r_st;
            r_oval <= r_val;
            r_oisb <= r_isb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_stat.cls      = e_cls;
    assign o_stat.exp_zero = (r_exp == '0);
    assign o_stat.exp_lsb  = r_exp[0];
    assign o_stat.out_busy = r_ovalid && !i_ready;
    assign o_valid         = r_ovalid;
    assign o_data          = {5'd0, r_oisb, r_oval, r_ost};
endmodule
`default_nettype wire

@@ rtl/core/checked_int_constant_alu.sv @@
// Top level of the checked 64-bit integer constant-folding ALU.
// Compare, logic, add, subtract, shift and unary words pass evaluation, then load the output;
// multiply and divide go from evaluation (start) through 64 steps and a finish to the output.
// Power: at most 11 multiplies, each a start, 64 steps and a write-back.
// One word at a time: the next word is taken the cycle after the result loads;
// a result held by the receiver holds the controller and the input.
// Reset (synchronous, active low) empties the output stage and idles the controller.
`default_nettype none
module checked_int_constant_alu
    import cica_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_s_tvalid,
    output logic                     o_s_tready,
    // tdata: operation[4:0], operand_count[6:5], left_kind[8:7],
    // left_value[72:9], right_kind[74:73], right_value[138:75], zero pad
    input  wire logic [IN_BITS-1:0]  i_s_tdata,
    output logic                     o_m_tvalid,
    input  wire logic                i_m_tready,
    // tdata: status[1:0], result_value[65:2], result_is_bool[66], zero pad
    output logic [OUT_BITS-1:0]      o_m_tdata
);
    t_cmd  cmd;
    t_stat stat;

    // Controller: walks each word through evaluation and the iterative unit.
    cica_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Datapath: holds operands, result and the output register.
    cica_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .i_data  (i_s_tdata),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_data  (o_m_tdata)
    );
endmodule
`default_nettype wire

@@ rtl/core/cica_chk.sv @@
// Port-level checker for the ALU, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module cica_chk
    import cica_pkg::*;
(
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_s_tvalid,
    input wire logic                o_s_tready,
    input wire logic [IN_BITS-1:0]  i_s_tdata,
    input wire logic                o_m_tvalid,
    input wire logic                i_m_tready,
    input wire logic [OUT_BITS-1:0] o_m_tdata
);
    `CHK_IMPLY(a_status_code, i_clk, i_rst_n, o_m_tvalid, o_m_tdata[1:0] != 2'd3)
    `CHK_IMPLY(a_unfolded_zero, i_clk, i_rst_n, o_m_tvalid && o_m_tdata[1:0] != ST_OK, o_m_tdata[66:2] == '0)
    `CHK_IMPLY(a_bool_range, i_clk, i_rst_n, o_m_tvalid && o_m_tdata[66], o_m_tdata[65:3] == '0)
    `CHK_NEXT(a_valid_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid)
endmodule

bind checked_int_constant_alu cica_chk u_chk (.*);
`default_nettype wire
